### src/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### src/rsp_pkg.sv
`default_nettype none
package rsp_pkg;

    localparam int DIV_NW = 46;
    localparam int DIV_DW = 32;
    localparam int SZ_NW  = 21;
    localparam int CEN_W  = 23;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y  = 3'd5;

    typedef struct packed {
        logic [15:0] sprite_x;
        logic [15:0] sprite_y;
    } t_sp_in;

    typedef struct packed {
        logic               visible;
        logic [15:0]        depth;
        logic signed [15:0] screen_center;
        logic [15:0]        sprite_size;
        logic [11:0]        first_column;
        logic [11:0]        last_column;
        logic [11:0]        first_row;
        logic [11:0]        last_row;
    } t_sp_out;

    typedef struct packed {
        logic                    alive;
        logic                    big;
        logic [15:0]             depth;
        logic signed [CEN_W-1:0] center;
    } t_sz_side;

endpackage
`default_nettype wire

### src/rsp_div.sv
`default_nettype none
module rsp_div #(
    parameter int NW = 46,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    // one quotient bit per stage, restoring
    logic          r_v [0:NW];
    logic [NW-1:0] r_q [0:NW];
    logic [DW-1:0] r_r [0:NW];
    logic [DW-1:0] r_d [0:NW];
    logic [SW-1:0] r_s [0:NW];

    assign r_v[0] = i_valid;
    assign r_q[0] = i_num;
    assign r_r[0] = '0;
    assign r_d[0] = i_den;
    assign r_s[0] = i_side;

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        take;

        assign trial = {r_r[g], r_q[g][NW-1]};
        assign diff  = trial - {1'b0, r_d[g]};
        assign take  = trial >= {1'b0, r_d[g]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_q[g+1] <= {r_q[g][NW-2:0], take};
            r_r[g+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
            r_d[g+1] <= r_d[g];
            r_s[g+1] <= r_s[g];
        end
    end

    assign o_valid = r_v[NW];
    assign o_quo   = r_q[NW];
    assign o_side  = r_s[NW];
endmodule
`default_nettype wire

### src/raycaster_sprite_projection.sv
`default_nettype none
// raycaster sprite projection
// input: pulse i_start with a sprite word on i_item; taken whenever o_busy is
//   low, and o_busy stays low, so one sprite may enter on every cycle
// output: o_strobe marks o_result for one cycle, in arrival order; the receiver
//   cannot hold results off
// latency is set by two pulled-apart long dividers of one quotient bit per
//   stage: depth and center column (46 stages, side by side) and then size
//   (21 stages), plus five front stages and two around the size divider
// config: i_cfg_valid/o_cfg_ready write one register per word at
//   i_cfg_index (player x, player y, dir x, dir y, plane x, plane y);
//   o_cfg_ready is always high and unknown indexes are dropped
// write config only while no sprite is in flight; a sprite may start on
//   the cycle after the last config word
// reset (synchronous, active low) restores the default camera and empties
//   the pipeline; words in flight are dropped
module raycaster_sprite_projection #(
    parameter int SCREEN_W = 640,
    parameter int SCREEN_H = 480
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  rsp_pkg::t_sp_in                 i_item,
    output logic                            o_strobe,
    output rsp_pkg::t_sp_out                o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import rsp_pkg::*;
`include "assert_macros.svh"

    localparam int HALF_W = SCREEN_W / 2;
    localparam int HWB    = $clog2(HALF_W + 1);
    localparam int CNW    = 33 + HWB;
    localparam logic [SZ_NW-1:0] SZ_NUM = SZ_NW'(SCREEN_H * 256);
    localparam int LAT    = 5 + DIV_NW + 1 + SZ_NW + 1;

    // config registers
    logic [15:0]        r_player_x, r_player_y;
    logic signed [15:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic signed [31:0] r_det_a, r_det_b;
    logic signed [32:0] r_det;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_x <= 16'd0;
            r_player_y <= 16'd0;
            r_dir_x    <= -16'sd16384;
            r_dir_y    <= 16'sd0;
            r_plane_x  <= 16'sd0;
            r_plane_y  <= 16'sd10813;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PLAYER_X: r_player_x <= i_cfg_data;
                CFG_PLAYER_Y: r_player_y <= i_cfg_data;
                CFG_DIR_X:    r_dir_x    <= $signed(i_cfg_data);
                CFG_DIR_Y:    r_dir_y    <= $signed(i_cfg_data);
                CFG_PLANE_X:  r_plane_x  <= $signed(i_cfg_data);
                CFG_PLANE_Y:  r_plane_y  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // determinant is registered from the config registers through r_det_a/r_det_b and then r_det
    always_ff @(posedge i_clk) begin
        r_det_a <= r_plane_x * r_dir_y;
        r_det_b <= r_dir_x * r_plane_y;
        r_det   <= 33'(r_det_a) - 33'(r_det_b);
    end

    // stage 1: offsets
    logic               r1_v;
    logic signed [16:0] r1_dx, r1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dx <= $signed({1'b0, i_item.sprite_x}) - $signed({1'b0, r_player_x});
        r1_dy <= $signed({1'b0, i_item.sprite_y}) - $signed({1'b0, r_player_y});
    end

    // stage 2: products
    logic               r2_v;
    logic signed [32:0] r2_pa, r2_pb, r2_pc, r2_pd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_pa <= r_dir_y * r1_dx;
        r2_pb <= r_dir_x * r1_dy;
        r2_pc <= r_plane_x * r1_dy;
        r2_pd <= r_plane_y * r1_dx;
    end

    // stage 3: camera space
    logic               r3_v;
    logic signed [33:0] r3_nx, r3_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_nx <= 34'(r2_pa) - 34'(r2_pb);
        r3_ny <= 34'(r2_pc) - 34'(r2_pd);
    end

    // stage 4: magnitudes and signs
    logic               r4_v;
    logic [31:0]        r4_ny_abs, r4_det_abs;
    logic [32:0]        r4_sum_abs;
    logic               r4_ny_neg, r4_sum_neg, r4_det_neg, r4_det_zero;
    logic signed [34:0] sum;
    logic signed [33:0] ny_neg_v;
    logic signed [34:0] sum_neg_v;
    logic signed [32:0] det_neg_v;

    assign sum       = 35'(r3_nx) + 35'(r3_ny);
    assign ny_neg_v  = -r3_ny;
    assign sum_neg_v = -sum;
    assign det_neg_v = -r_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_ny_neg   <= r3_ny[33];
        r4_ny_abs   <= r3_ny[33] ? ny_neg_v[31:0] : r3_ny[31:0];
        r4_sum_neg  <= sum[34];
        r4_sum_abs  <= sum[34] ? sum_neg_v[32:0] : sum[32:0];
        r4_det_neg  <= r_det[32];
        r4_det_abs  <= r_det[32] ? det_neg_v[31:0] : r_det[31:0];
        r4_det_zero <= (r_det == 33'sd0);
    end

    // stage 5: divider operands
    logic              r5_v;
    logic [DIV_NW-1:0] r5_dnum, r5_cnum;
    logic [DIV_DW-1:0] r5_dden, r5_cden;
    logic              r5_det_zero, r5_dneg, r5_cneg;
    logic [CNW-1:0]    cprod;

    assign cprod = CNW'(r4_sum_abs) * CNW'(HALF_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_dnum     <= {r4_ny_abs, 14'd0};
        r5_dden     <= r4_det_abs;
        r5_cnum     <= {{(DIV_NW-CNW){1'b0}}, cprod};
        r5_cden     <= r4_ny_abs;
        r5_det_zero <= r4_det_zero;
        r5_dneg     <= r4_ny_neg ^ r4_det_neg;
        r5_cneg     <= r4_sum_neg ^ r4_ny_neg;
    end

    // depth and center dividers
    logic              dv_v;
    logic [DIV_NW-1:0] dv_q, cv_q;
    logic [1:0]        dv_side;
    logic [0:0]        cv_side;

    rsp_div #(.NW(DIV_NW), .DW(DIV_DW), .SW(2)) u_depth_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_num   (r5_dnum),
        .i_den   (r5_dden),
        .i_side  ({r5_det_zero, r5_dneg}),
        .o_valid (dv_v),
        .o_quo   (dv_q),
        .o_side  (dv_side)
    );

    rsp_div #(.NW(DIV_NW), .DW(DIV_DW), .SW(1)) u_center_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_num   (r5_cnum),
        .i_den   (r5_cden),
        .i_side  (r5_cneg),
        .o_valid (),
        .o_quo   (cv_q),
        .o_side  (cv_side)
    );

    // size divider operands
    logic              r6_v;
    logic [SZ_NW-1:0]  r6_den;
    t_sz_side          r6_side;
    logic [CEN_W-2:0]  cmag;
    logic [CEN_W-1:0]  cmag_neg;

    assign cmag     = (|cv_q[DIV_NW-1:CEN_W-1]) ? {(CEN_W-1){1'b1}} : cv_q[CEN_W-2:0];
    assign cmag_neg = -{1'b0, cmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_den         <= dv_q[SZ_NW-1:0];
        r6_side.alive  <= !dv_side[1] && !dv_side[0] && (dv_q != '0);
        r6_side.big    <= |dv_q[DIV_NW-1:SZ_NW];
        r6_side.depth  <= (|dv_q[DIV_NW-1:16]) ? 16'hFFFF : dv_q[15:0];
        r6_side.center <= cv_side[0] ? $signed(cmag_neg) : $signed({1'b0, cmag});
    end

    logic                       sv_v;
    logic [SZ_NW-1:0]           sv_q;
    logic [$bits(t_sz_side)-1:0] sv_side_raw;
    t_sz_side                   sv_side;

    rsp_div #(.NW(SZ_NW), .DW(SZ_NW), .SW($bits(t_sz_side))) u_size_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_v),
        .i_num   (SZ_NUM),
        .i_den   (r6_den),
        .i_side  (r6_side),
        .o_valid (sv_v),
        .o_quo   (sv_q),
        .o_side  (sv_side_raw)
    );

    assign sv_side = t_sz_side'(sv_side_raw);

    // spans and output register
    function automatic logic [11:0] clamp_span(input logic signed [24:0] v,
                                                input logic [11:0] hi);
        logic [11:0] res;
        if (v < 25'sd0) begin
            res = 12'd0;
        end else if (v > $signed({13'd0, hi})) begin
            res = hi;
        end else begin
            res = v[11:0];
        end
        return res;
    endfunction

    logic [SZ_NW-1:0]   size;
    logic signed [24:0] half_s, cen_s, mid_s;
    logic [11:0]        c0, c1, rw0, rw1;
    logic signed [15:0] cen16;
    t_sp_out            n_result;

    assign size   = sv_side.big ? '0 : sv_q;
    assign half_s = $signed({{(25-SZ_NW+1){1'b0}}, size[SZ_NW-1:1]});
    assign cen_s  = {{(25-CEN_W){sv_side.center[CEN_W-1]}}, sv_side.center};
    assign mid_s  = $signed(25'(SCREEN_H / 2));
    assign c0     = clamp_span(cen_s - half_s, 12'(SCREEN_W - 1));
    assign c1     = clamp_span(cen_s + half_s, 12'(SCREEN_W - 1));
    assign rw0    = clamp_span(mid_s - half_s, 12'(SCREEN_H - 1));
    assign rw1    = clamp_span(mid_s + half_s, 12'(SCREEN_H - 1));
    assign cen16  = (sv_side.center[CEN_W-1:15] != {(CEN_W-15){sv_side.center[CEN_W-1]}})
                  ? (sv_side.center[CEN_W-1] ? 16'sh8000 : 16'sh7FFF)
                  : sv_side.center[15:0];

    always_comb begin
        n_result = '0;
        if (sv_side.alive) begin
            n_result.visible       = (c0 < c1) && (rw0 < rw1);
            n_result.depth         = sv_side.depth;
            n_result.screen_center = cen16;
            n_result.sprite_size   = (|size[SZ_NW-1:16]) ? 16'hFFFF : size[15:0];
            n_result.first_column  = c0;
            n_result.last_column   = c1;
            n_result.first_row     = rw0;
            n_result.last_row      = rw1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= sv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_result;
    end

    `ASSERT_IMPLY(a_vis_span, i_clk, i_rst_n, o_strobe && o_result.visible,
        (o_result.first_column < o_result.last_column) && (o_result.first_row < o_result.last_row))
    `ASSERT_IMPLY(a_dead_zero, i_clk, i_rst_n, o_strobe && (o_result.depth == 16'd0),
        !o_result.visible && (o_result.sprite_size == 16'd0))
    `ASSERT_IMPLY(a_latency, i_clk, i_rst_n, o_strobe, $past(i_start && !o_busy, LAT))
    `ASSERT_NEVER(a_busy_low, i_clk, i_rst_n, o_busy)

endmodule
`default_nettype wire

### test/tb.sv
`default_nettype none
module tb;
    import rsp_pkg::*;

    localparam int SCR_W = 640;
    localparam int SCR_H = 480;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;
    localparam int LIMIT = 400000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_start = 1'b0;
    logic            o_busy;
    t_sp_in          i_item = '0;
    logic            o_strobe;
    t_sp_out         o_result;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_PLAYER_X;
    logic [15:0]     i_cfg_data = '0;

    raycaster_sprite_projection #(.SCREEN_W(SCR_W), .SCREEN_H(SCR_H)) dut (.*);

    always #10 i_clk = ~i_clk;

    // camera as the block should hold it
    logic [15:0]        cam_px, cam_py;
    logic signed [15:0] cam_dx, cam_dy, cam_plx, cam_ply;

    t_sp_out proj_q[$];
    int errors = 0;
    int taken = 0;
    int cfg_taken = 0;
    int results_seen = 0;
    int visible_seen = 0;
    int cycles = 0;
    int idle_pct = 0;

    function automatic longint clampl(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_sp_out project(t_sp_in s);
        t_sp_out r;
        longint dx, dy, det, nx, ny, dep, cen, sz, half, c0, c1, r0, r1;
        r = '0;
        dx = longint'(s.sprite_x) - longint'(cam_px);
        dy = longint'(s.sprite_y) - longint'(cam_py);
        det = longint'(cam_plx) * longint'(cam_dy) - longint'(cam_dx) * longint'(cam_ply);
        if (det == 0) return r;
        nx = longint'(cam_dy) * dx - longint'(cam_dx) * dy;
        ny = longint'(cam_plx) * dy - longint'(cam_ply) * dx;
        dep = (ny * 16384) / det;
        if (dep <= 0) return r;
        cen = (longint'(SCR_W / 2) * (ny + nx)) / ny;
        sz = (longint'(SCR_H) * 256) / dep;
        half = sz / 2;
        r0 = clampl(SCR_H / 2 - half, 0, SCR_H - 1);
        r1 = clampl(SCR_H / 2 + half, 0, SCR_H - 1);
        c0 = clampl(cen - half, 0, SCR_W - 1);
        c1 = clampl(cen + half, 0, SCR_W - 1);
        r.visible = (c0 < c1) && (r0 < r1);
        r.depth = 16'(clampl(dep, 0, 65535));
        r.screen_center = 16'(clampl(cen, -32768, 32767));
        r.sprite_size = 16'(clampl(sz, 0, 65535));
        r.first_column = 12'(c0);
        r.last_column = 12'(c1);
        r.first_row = 12'(r0);
        r.last_row = 12'(r1);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sp_out e;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PLAYER_X: cam_px = i_cfg_data;
                    CFG_PLAYER_Y: cam_py = i_cfg_data;
                    CFG_DIR_X:    cam_dx = i_cfg_data;
                    CFG_DIR_Y:    cam_dy = i_cfg_data;
                    CFG_PLANE_X:  cam_plx = i_cfg_data;
                    CFG_PLANE_Y:  cam_ply = i_cfg_data;
                    default: ;
                endcase
                cfg_taken = cfg_taken + 1;
            end
            if (o_strobe) begin
                results_seen = results_seen + 1;
                if (proj_q.size() == 0) begin
                    $error("result word with nothing expected");
                    errors = errors + 1;
                end else begin
                    e = proj_q.pop_front();
                    if (o_result.visible) visible_seen = visible_seen + 1;
                    if (o_result.visible !== e.visible) begin
                        $error("visible exp %0d got %0d", e.visible, o_result.visible);
                        errors = errors + 1;
                    end
                    if (o_result.depth !== e.depth) begin
                        $error("depth exp %0d got %0d", e.depth, o_result.depth);
                        errors = errors + 1;
                    end
                    if (o_result.screen_center !== e.screen_center) begin
                        $error("screen_center exp %0d got %0d", e.screen_center,
                               o_result.screen_center);
                        errors = errors + 1;
                    end
                    if (o_result.sprite_size !== e.sprite_size) begin
                        $error("sprite_size exp %0d got %0d", e.sprite_size,
                               o_result.sprite_size);
                        errors = errors + 1;
                    end
                    if (o_result.first_column !== e.first_column) begin
                        $error("first_column exp %0d got %0d", e.first_column,
                               o_result.first_column);
                        errors = errors + 1;
                    end
                    if (o_result.last_column !== e.last_column) begin
                        $error("last_column exp %0d got %0d", e.last_column,
                               o_result.last_column);
                        errors = errors + 1;
                    end
                    if (o_result.first_row !== e.first_row) begin
                        $error("first_row exp %0d got %0d", e.first_row, o_result.first_row);
                        errors = errors + 1;
                    end
                    if (o_result.last_row !== e.last_row) begin
                        $error("last_row exp %0d got %0d", e.last_row, o_result.last_row);
                        errors = errors + 1;
                    end
                end
            end
            if (i_start && !o_busy) begin
                proj_q.push_back(project(i_item));
                taken = taken + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // leaves i_start high at a falling edge once the word is taken
    task automatic send_sprite(input logic [15:0] sx, input logic [15:0] sy);
        int target;
        while ($urandom_range(99) < idle_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        target = taken + 1;
        i_start = 1'b1;
        i_item.sprite_x = sx;
        i_item.sprite_y = sy;
        do @(negedge i_clk); while (taken < target);
    endtask

    task automatic wait_drained();
        i_start = 1'b0;
        while (proj_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        int target;
        target = cfg_taken + 1;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(negedge i_clk); while (cfg_taken < target);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_camera(input logic [15:0] px, input logic [15:0] py,
                              input logic [15:0] dx, input logic [15:0] dy,
                              input logic [15:0] plx, input logic [15:0] ply);
        wait_drained();
        write_cfg(CFG_PLAYER_X, px);
        write_cfg(CFG_PLAYER_Y, py);
        write_cfg(CFG_DIR_X, dx);
        write_cfg(CFG_DIR_Y, dy);
        write_cfg(CFG_PLANE_X, plx);
        write_cfg(CFG_PLANE_Y, ply);
    endtask

    function automatic logic [15:0] pick_reg();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'h7fff;
            2: return 16'h8000;
            3: return 16'hffff;
            4, 5: return 16'($signed(16'h4000) * ($urandom_range(1) ? 1 : -1));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_reset_camera();
        send_sprite(16'h0000, 16'h0000);
        send_sprite(16'hffff, 16'hffff);
        send_sprite(16'h0000, 16'hffff);
        send_sprite(16'hffff, 16'h0000);
    endtask

    task automatic test_directed();
        // player mid map looking toward -x
        set_camera(16'h8000, 16'h8000, 16'hc000, 16'h0000, 16'h0000, 16'h2a3d);
        send_sprite(16'h7c00, 16'h8000);
        send_sprite(16'h7fff, 16'h8000);
        send_sprite(16'h0000, 16'h8000);
        send_sprite(16'h8400, 16'h8000);
        send_sprite(16'h8000, 16'h8000);
        send_sprite(16'h7e00, 16'h9000);
        send_sprite(16'h7e00, 16'h7000);
        send_sprite(16'h7ff0, 16'h8001);
        send_sprite(16'h0000, 16'hffff);
        send_sprite(16'h0000, 16'h0000);
        // extreme camera registers
        set_camera(16'hffff, 16'h0000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_sprite(16'h0000, 16'hffff);
        send_sprite(16'hfff0, 16'h0100);
        send_sprite(16'hffff, 16'h0000);
        // singular camera
        set_camera(16'h8000, 16'h8000, 16'h4000, 16'h0000, 16'h4000, 16'h0000);
        send_sprite(16'h9000, 16'h8000);
        send_sprite(16'h1234, 16'hfedc);
        wait_drained();
        write_cfg(CFG_SPARE, 16'h1234);
        write_cfg(CFG_SPARE + 3'd1, 16'hffff);
        send_sprite(16'h9000, 16'h8100);
    endtask

    task automatic test_random(input int pct, input int n);
        logic [15:0] sx, sy;
        idle_pct = 0;
        set_camera(pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg());
        if ($urandom_range(3) == 0) write_cfg(CFG_SPARE, 16'($urandom));
        idle_pct = pct;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) < 7) begin
                // near the player, where sprites are more likely to project onto the screen
                sx = cam_px + 16'($signed(11'($urandom)));
                sy = cam_py + 16'($signed(11'($urandom)));
            end else begin
                sx = 16'($urandom);
                sy = 16'($urandom);
            end
            if (k % 25 == 0 && $urandom_range(3) == 0) begin
                wait_drained();
                set_camera(pick_reg(), pick_reg(), pick_reg(), pick_reg(),
                           pick_reg(), pick_reg());
            end
            send_sprite(sx, sy);
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        cam_px = 16'h0000;
        cam_py = 16'h0000;
        cam_dx = -16'sd16384;
        cam_dy = 16'sd0;
        cam_plx = 16'sd0;
        cam_ply = 16'sd10813;
        test_reset_camera();
        test_directed();
        test_random(0, 125);
        test_random(75, 125);
        test_random(9, 125);
        test_random(0, 125);
        wait_drained();
        repeat (100) @(negedge i_clk);
        if (proj_q.size() != 0) begin
            $error("%0d expected words never came", proj_q.size());
            errors = errors + 1;
        end
        $display("%0d sprites sent, %0d results checked, %0d visible", taken,
                 results_seen, visible_seen);
        $display("camera settings included extremes, a singular camera and spare indexes");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
